// ----- design/cse_pkg.sv -----
// ----------------------------------------------------------------------------
// cse_pkg: shared types and constants for the Chebyshev series evaluator
// Q8.24 value format, register indexes, operation codes and the status
// structs passed between the sequencer and its arithmetic units.
// ----------------------------------------------------------------------------
package cse_pkg;

	localparam int VAL_W     = 32;
	localparam int FRAC_BITS = 24;
	localparam int MAX_TERMS = 16;
	localparam int IDX_W     = $clog2(MAX_TERMS);
	localparam int CFG_IDX_W = 2;
	// 2u - low - high needs two bits of headroom
	localparam int NUM_W     = VAL_W + 2;

	typedef logic signed [VAL_W-1:0] value_t;
	typedef logic signed [NUM_W-1:0] num_t;
	typedef logic [VAL_W-1:0]        den_t;
	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

	localparam value_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam value_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	// reset interval is [0.0, 1.0]
	localparam value_t INTERVAL_LOW_RST  = '0;
	localparam value_t INTERVAL_HIGH_RST = value_t'(1) <<< FRAC_BITS;

	localparam cfg_idx_t CFG_INTERVAL_LOW  = 2'd0;
	localparam cfg_idx_t CFG_INTERVAL_HIGH = 2'd1;
	localparam cfg_idx_t CFG_SERIES_ORDER  = 2'd2;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	typedef struct packed {
		logic   done;
		logic   sat;
		value_t y;
	} div_res_t;

	typedef struct packed {
		logic   done;
		logic   sat;
		value_t value;
	} series_res_t;

endpackage

// ----- design/cse_channels.sv -----
// ----------------------------------------------------------------------------
// cse_channels: valid/ready channels of the Chebyshev series evaluator
// cse_item_if carries one input word, cse_result_if one result word.
// ----------------------------------------------------------------------------
interface cse_item_if;
	import cse_pkg::*;

	logic   valid;
	logic   ready;
	logic   op;
	idx_t   coef_index;
	value_t operand_value;

	modport source (output valid, output op, output coef_index, output operand_value,
		input ready);
	modport sink (input valid, input op, input coef_index, input operand_value,
		output ready);
endinterface

interface cse_result_if;
	import cse_pkg::*;

	logic   valid;
	logic   ready;
	value_t series_value;
	logic   saturated_flag;

	modport source (output valid, output series_value, output saturated_flag,
		input ready);
	modport sink (input valid, input series_value, input saturated_flag,
		output ready);
endinterface

// ----- design/cse_coef_mem.sv -----
// ----------------------------------------------------------------------------
// cse_coef_mem: coefficient table
// One write port, one registered read port. Contents are undefined until
// written.
// ----------------------------------------------------------------------------
module cse_coef_mem (
	input  logic            clk,
	input  logic            we,
	input  cse_pkg::idx_t   waddr,
	input  cse_pkg::value_t wdata,
	input  cse_pkg::idx_t   raddr,
	output cse_pkg::value_t rdata
);
	import cse_pkg::*;

	value_t mem_q [MAX_TERMS];
	value_t rdata_q;

	// write on load words, read every cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/cse_divider.sv -----
// ----------------------------------------------------------------------------
// cse_divider: iterative restoring divider for the interval mapping
// Computes trunc(num * 2^FRAC_BITS / den) for den > 0, one quotient bit per
// cycle, and saturates the result to the Q8.24 range.
// ----------------------------------------------------------------------------
module cse_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cse_pkg::num_t     num,
	input  cse_pkg::den_t     den,
	output cse_pkg::div_res_t res
);
	import cse_pkg::*;

	localparam int DIV_STEPS = VAL_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	// quotient fits VAL_W bits iff |num| < den * 2^SH
	localparam int SH        = VAL_W - FRAC_BITS;
	localparam int CMP_W     = VAL_W + SH;

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_INIT = 2'd1;
	localparam logic [1:0] D_RUN  = 2'd2;
	localparam logic [1:0] D_FIN  = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] mag_q;
	logic             neg_q;
	den_t             den_q;
	logic             ovf_q;
	logic [VAL_W-1:0] rem_q;
	logic [VAL_W-1:0] quo_q;

	logic [NUM_W-1:0] mag_d;
	logic             ovf_d;
	logic [VAL_W:0]   part;
	logic [VAL_W:0]   diff;
	logic             ge;
	value_t           y_d;
	logic             sat_d;

	// magnitude of the numerator
	assign mag_d = num[NUM_W-1] ? (~num + 1'b1) : num;

	// quotient overflow check
	assign ovf_d = {{(CMP_W-NUM_W){1'b0}}, mag_q} >= {den_q, {SH{1'b0}}};

	// one restoring step: shift in next dividend bit, try subtract
	assign part = {rem_q, quo_q[VAL_W-1]};
	assign diff = part - {1'b0, den_q};
	assign ge   = part >= {1'b0, den_q};

	// apply sign and saturate
	always_comb begin
		y_d   = value_t'(quo_q);
		sat_d = 1'b0;
		if (ovf_q) begin
			y_d   = neg_q ? VAL_MIN : VAL_MAX;
			sat_d = 1'b1;
		end else if (!neg_q) begin
			if (quo_q[VAL_W-1]) begin
				y_d   = VAL_MAX;
				sat_d = 1'b1;
			end
		end else begin
			if (quo_q > VAL_MIN) begin
				y_d   = VAL_MIN;
				sat_d = 1'b1;
			end else begin
				y_d = value_t'(~quo_q + 1'b1);
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_INIT;
					end
				end
				D_INIT: begin
					cnt_q   <= '0;
					state_q <= ovf_d ? D_FIN : D_RUN;
				end
				D_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= D_FIN;
					end
				end
				D_FIN: begin
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			D_IDLE: begin
				if (start) begin
					mag_q <= mag_d;
					neg_q <= num[NUM_W-1];
					den_q <= den;
				end
			end
			D_INIT: begin
				ovf_q <= ovf_d;
				rem_q <= VAL_W'(mag_q[NUM_W-1:SH]);
				quo_q <= {mag_q[SH-1:0], {FRAC_BITS{1'b0}}};
			end
			D_RUN: begin
				rem_q <= ge ? diff[VAL_W-1:0] : part[VAL_W-1:0];
				quo_q <= {quo_q[VAL_W-2:0], ge};
			end
			default: begin
			end
		endcase
	end

	assign res.done = (state_q == D_FIN);
	assign res.sat  = sat_d;
	assign res.y    = y_d;

endmodule

// ----- design/cse_clenshaw.sv -----
// ----------------------------------------------------------------------------
// cse_clenshaw: Clenshaw recurrence on one shared multiply-add unit
// Each step: multiply y*d1 in C_MUL, then add the shifted product, -d2 and
// the coefficient with saturation. The last step forms y*d1 - d2 + c0/2.
// ----------------------------------------------------------------------------
module cse_clenshaw (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  cse_pkg::value_t      y,
	input  cse_pkg::idx_t        order,
	output cse_pkg::idx_t        rd_addr,
	input  cse_pkg::value_t      rd_data,
	output cse_pkg::series_res_t res
);
	import cse_pkg::*;

	localparam int PROD_W = 2 * VAL_W;
	// shifted product plus two Q8.24 terms
	localparam int SUM_W  = PROD_W - FRAC_BITS + 3;

	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_MUL  = 2'd1;
	localparam logic [1:0] C_ADD  = 2'd2;
	localparam logic [1:0] C_DONE = 2'd3;

	logic [1:0]               state_q;
	value_t                   y_q;
	value_t                   d1_q;
	value_t                   d2_q;
	idx_t                     idx_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     sat_q;
	value_t                   value_q;

	logic                     last;
	logic signed [SUM_W-1:0]  term_p;
	logic signed [SUM_W-1:0]  term_c;
	logic signed [SUM_W-1:0]  sum;
	logic                     fits;
	value_t                   sum_sat;

	assign last = (idx_q == '0);

	// shared adder: 2*y*d1 - d2 + c[i] on inner steps, y*d1 - d2 + c0/2 on the last
	assign term_p = last ? SUM_W'(prod_q >>> FRAC_BITS) : SUM_W'(prod_q >>> (FRAC_BITS - 1));
	assign term_c = last ? SUM_W'(rd_data >>> 1) : SUM_W'(rd_data);
	assign sum    = term_p - SUM_W'(d2_q) + term_c;

	// saturate to the value range
	assign fits    = (&sum[SUM_W-1:VAL_W-1]) | ~(|sum[SUM_W-1:VAL_W-1]);
	assign sum_sat = fits ? sum[VAL_W-1:0] : (sum[SUM_W-1] ? VAL_MIN : VAL_MAX);

	// step sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= C_MUL;
					end
				end
				C_MUL: begin
					state_q <= C_ADD;
				end
				C_ADD: begin
					state_q <= last ? C_DONE : C_MUL;
				end
				C_DONE: begin
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	// recurrence registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: begin
				if (start) begin
					y_q   <= y;
					d1_q  <= '0;
					d2_q  <= '0;
					idx_q <= order;
					sat_q <= 1'b0;
				end
			end
			C_MUL: begin
				prod_q <= y_q * d1_q;
			end
			C_ADD: begin
				sat_q <= sat_q | ~fits;
				if (last) begin
					value_q <= sum_sat;
				end else begin
					d1_q  <= sum_sat;
					d2_q  <= d1_q;
					idx_q <= idx_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign rd_addr   = idx_q;
	assign res.done  = (state_q == C_DONE);
	assign res.sat   = sat_q;
	assign res.value = value_q;

endmodule

// ----- design/chebyshev_series_evaluator_unit.sv -----
// Load word: written to the coefficient table when taken; the block stays ready.
// Evaluate word: the one-bit-per-cycle divider maps u, its bit steps skipped when
// the quotient overflows; then the Clenshaw recurrence runs down from series_order.
// Empty interval: result 0, flag set. No new word is taken while one evaluates.
// A finished result waits in the output register while new words are taken.
// Reset restores the interval to [0, 1] and order 0; coefficient table is undefined.
// ----------------------------------------------------------------------------
// chebyshev_series_evaluator_unit: Chebyshev series evaluation, Clenshaw form
// Maps u onto [-1, 1] with an iterative divider, then runs the Clenshaw
// recurrence over the coefficient table on a shared multiply-add unit.
// ----------------------------------------------------------------------------
module chebyshev_series_evaluator_unit (
	input  logic              clk,
	input  logic              arst_n,
	cse_item_if.sink          in_ch,
	cse_result_if.source      out_ch,
	input  logic              cfg_we,
	input  cse_pkg::cfg_idx_t cfg_index,
	input  cse_pkg::value_t   cfg_wdata
);
	import cse_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_PREP   = 3'd1;
	localparam logic [2:0] S_CHK    = 3'd2;
	localparam logic [2:0] S_DIV    = 3'd3;
	localparam logic [2:0] S_SERIES = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0]  state_q;
	value_t      low_q;
	value_t      high_q;
	idx_t        order_q;
	value_t      u_q;
	num_t        num_q;
	den_t        den_q;
	logic        empty_q;
	logic        div_sat_q;
	value_t      res_value_q;
	logic        res_sat_q;
	logic        out_valid_q;
	value_t      out_value_q;
	logic        out_flag_q;

	logic        in_acc;
	logic        mem_we;
	logic        div_start;
	logic        series_start;
	logic        out_free;
	idx_t        rd_addr;
	value_t      rd_data;
	div_res_t    div_res;
	series_res_t ser_res;

	assign in_ch.ready  = (state_q == S_IDLE);
	assign in_acc       = in_ch.valid & in_ch.ready;
	assign mem_we       = in_acc & (in_ch.op == OP_LOAD);
	assign div_start    = (state_q == S_CHK) & ~empty_q;
	assign series_start = (state_q == S_DIV) & div_res.done;
	assign out_free     = ~out_valid_q | out_ch.ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= INTERVAL_LOW_RST;
			high_q  <= INTERVAL_HIGH_RST;
			order_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INTERVAL_LOW:  low_q   <= cfg_wdata;
				CFG_INTERVAL_HIGH: high_q  <= cfg_wdata;
				CFG_SERIES_ORDER:  order_q <= cfg_wdata[IDX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && in_ch.op == OP_EVAL) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					state_q <= empty_q ? S_DONE : S_DIV;
				end
				S_DIV: begin
					if (div_res.done) begin
						state_q <= S_SERIES;
					end
				end
				S_SERIES: begin
					if (ser_res.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// hold the result word until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// evaluation datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			u_q <= in_ch.operand_value;
		end
		if (state_q == S_PREP) begin
			num_q   <= (num_t'(u_q) <<< 1) - num_t'(low_q) - num_t'(high_q);
			den_q   <= den_t'(high_q - low_q);
			empty_q <= (low_q >= high_q);
		end
		if (state_q == S_CHK && empty_q) begin
			res_value_q <= '0;
			res_sat_q   <= 1'b1;
		end
		if (series_start) begin
			div_sat_q <= div_res.sat;
		end
		if (state_q == S_SERIES && ser_res.done) begin
			res_value_q <= ser_res.value;
			res_sat_q   <= div_sat_q | ser_res.sat;
		end
		if (state_q == S_DONE && out_free) begin
			out_value_q <= res_value_q;
			out_flag_q  <= res_sat_q;
		end
	end

	cse_coef_mem u_coef_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (in_ch.coef_index),
		.wdata (in_ch.operand_value),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	cse_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.res    (div_res)
	);

	cse_clenshaw u_clenshaw (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (series_start),
		.y       (div_res.y),
		.order   (order_q),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.res     (ser_res)
	);

	assign out_ch.valid          = out_valid_q;
	assign out_ch.series_value   = out_value_q;
	assign out_ch.saturated_flag = out_flag_q;

endmodule
